@@ hdl/block_range_device_splitter_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the block range device splitter
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef BLOCK_RANGE_DEVICE_SPLITTER_ASSERT_SVH
`define BLOCK_RANGE_DEVICE_SPLITTER_ASSERT_SVH

// Same-cycle implication.
`define BRDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BRDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/brds_pkg.sv @@
// ----------------------------------------------------------------------------
// brds_pkg
// Types and constants shared by the block range device splitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brds_pkg;

  localparam int DATA_W = 64;
  localparam int DEV_W  = 4;
  localparam int CNT_W  = 5;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SPLIT  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_COUNT_RD,
    ST_COUNT_EV,
    ST_EMIT_RD,
    ST_EMIT_EV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [DATA_W-1:0] device_blocks;
    logic [DATA_W-1:0] range_start;
    logic [DATA_W-1:0] range_end;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] piece_start;
    logic [DATA_W-1:0] piece_end;
    logic [DEV_W-1:0]  device_index;
    logic [CNT_W-1:0]  piece_count;
    logic              last;
    logic              out_of_range;
  } out_item_t;

  // Results of the shared compare unit for one device window [lo, hi).
  typedef struct packed {
    logic              nonempty;
    logic              touched;
    logic              rs_gt_re;
    logic              hi_gt_re;
    logic [DATA_W-1:0] piece_start;
    logic [DATA_W-1:0] piece_end;
  } cmp_res_t;

endpackage

@@ hdl/brds_stream_if.sv @@
// ----------------------------------------------------------------------------
// brds_stream_if
// Valid/ready channel carrying one payload item per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface brds_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/block_range_device_splitter.sv @@
// ----------------------------------------------------------------------------
// block_range_device_splitter
// Keeps a table of device start boundaries and splits block ranges into
// one piece per device touched.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | Payload       | Notes
//  ---------+-----+---------------+-------------------------------------------
//  in_ch    | in  | in_item_t     | clear / append / split requests
//  out_ch   | out | out_item_t    | pieces, one or more per split request
//
// Clear, append and no-op requests are done when accepted. A split with zero
// or one device registers its single result when accepted; one that is
// flagged in the check state registers it there. Otherwise a split passes
// through the check state, a counting sweep over all devices, an emitting
// sweep up to the last device touched, and an output state per piece
// delivered. Each sweep has a read and an evaluate state per device; these
// come from the boundary memory's single registered read port feeding the
// compare unit.
// Reset empties the device table at once; no clearing pass is needed.
// A stalled output holds the block in place; no request is taken meanwhile.
`timescale 1ns / 1ps
`include "block_range_device_splitter_assert.svh"

module block_range_device_splitter #(
  parameter int MAX_DEVICES = 16
) (
  input logic          clk,
  input logic          rst_n,
  brds_stream_if.sink   in_ch,
  brds_stream_if.source out_ch
);

  localparam int AW = $clog2(MAX_DEVICES + 1);
  localparam int IW = $clog2(MAX_DEVICES);
  localparam int DW = brds_pkg::DATA_W;

  brds_pkg::state_t    state_r, state_nxt;
  logic [AW-1:0]       total_r, total_nxt;
  logic [DW-1:0]       last_bound_r, last_bound_nxt;
  logic [DW-1:0]       rs_r, rs_nxt;
  logic [DW-1:0]       re_r, re_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [DW-1:0]       lo_r, lo_nxt;
  logic [AW-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]       k_r, k_nxt;
  brds_pkg::out_item_t out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Boundary memory: entry j is the first block of device j; entry zero is
  // always 0 and is not stored.
  logic [DW-1:0]       bound_mem [1:MAX_DEVICES];
  logic [DW-1:0]       rd_data_r;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [DW-1:0]       wr_data;

  logic                in_acc;
  logic                out_acc;
  logic [IW-1:0]       last_idx;
  logic                at_last_idx;
  logic [DW:0]         app_sum;
  logic [DW-1:0]       app_bound;
  logic [DW-1:0]       cmp_hi;
  brds_pkg::cmp_res_t  cmp;
  brds_pkg::op_t       op;

  assign in_ch.ready  = (state_r == brds_pkg::ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;
  assign out_acc      = out_valid_r && out_ch.ready;
  assign op           = brds_pkg::op_t'(in_ch.data.opcode);

  assign last_idx    = IW'(total_r - 1'b1);
  assign at_last_idx = (idx_r == last_idx);
  assign rd_addr     = AW'(idx_r) + 1'b1;

  assign app_sum   = {1'b0, last_bound_r} + {1'b0, in_ch.data.device_blocks};
  assign app_bound = app_sum[DW] ? {DW{1'b1}} : app_sum[DW-1:0];

  // The check cycle compares against the volume size; the sweeps compare
  // against the boundary just read.
  assign cmp_hi = (state_r == brds_pkg::ST_CHECK) ? last_bound_r : rd_data_r;

  brds_cmp_unit u_cmp (
    .lo  (lo_r),
    .hi  (cmp_hi),
    .rs  (rs_r),
    .re  (re_r),
    .res (cmp)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bound_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= bound_mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      brds_pkg::ST_IDLE: begin
        if (in_acc && op == brds_pkg::OP_SPLIT) begin
          state_nxt = (total_r <= AW'(1)) ? brds_pkg::ST_OUT : brds_pkg::ST_CHECK;
        end
      end
      brds_pkg::ST_CHECK: begin
        if (cmp.rs_gt_re || !cmp.hi_gt_re) begin
          state_nxt = brds_pkg::ST_OUT;
        end else begin
          state_nxt = brds_pkg::ST_COUNT_RD;
        end
      end
      brds_pkg::ST_COUNT_RD: state_nxt = brds_pkg::ST_COUNT_EV;
      brds_pkg::ST_COUNT_EV: begin
        state_nxt = at_last_idx ? brds_pkg::ST_EMIT_RD : brds_pkg::ST_COUNT_RD;
      end
      brds_pkg::ST_EMIT_RD: state_nxt = brds_pkg::ST_EMIT_EV;
      brds_pkg::ST_EMIT_EV: begin
        if (cmp.touched) begin
          state_nxt = brds_pkg::ST_OUT;
        end else if (at_last_idx) begin
          state_nxt = brds_pkg::ST_IDLE;
        end else begin
          state_nxt = brds_pkg::ST_EMIT_RD;
        end
      end
      brds_pkg::ST_OUT: begin
        if (out_acc) begin
          state_nxt = out_r.last ? brds_pkg::ST_IDLE : brds_pkg::ST_EMIT_RD;
        end
      end
      default: state_nxt = brds_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    total_nxt      = total_r;
    last_bound_nxt = last_bound_r;
    rs_nxt         = rs_r;
    re_nxt         = re_r;
    idx_nxt        = idx_r;
    lo_nxt         = lo_r;
    cnt_nxt        = cnt_r;
    k_nxt          = k_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    wr_en          = 1'b0;
    wr_addr        = total_r + 1'b1;
    wr_data        = app_bound;
    case (state_r)
      brds_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (op)
            brds_pkg::OP_CLEAR: begin
              total_nxt      = '0;
              last_bound_nxt = '0;
            end
            brds_pkg::OP_APPEND: begin
              if (total_r < AW'(MAX_DEVICES)) begin
                wr_en          = 1'b1;
                total_nxt      = total_r + 1'b1;
                last_bound_nxt = app_bound;
              end
            end
            brds_pkg::OP_SPLIT: begin
              rs_nxt = in_ch.data.range_start;
              re_nxt = in_ch.data.range_end;
              if (total_r <= AW'(1)) begin
                out_nxt.piece_start  = in_ch.data.range_start;
                out_nxt.piece_end    = in_ch.data.range_end;
                out_nxt.device_index = '0;
                out_nxt.piece_count  = brds_pkg::CNT_W'(1);
                out_nxt.last         = 1'b1;
                out_nxt.out_of_range = 1'b0;
                out_valid_nxt        = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      brds_pkg::ST_CHECK: begin
        idx_nxt = '0;
        lo_nxt  = '0;
        cnt_nxt = '0;
        if (cmp.rs_gt_re || !cmp.hi_gt_re) begin
          out_nxt.piece_start  = rs_r;
          out_nxt.piece_end    = re_r;
          out_nxt.device_index = '0;
          out_nxt.piece_count  = brds_pkg::CNT_W'(1);
          out_nxt.last         = 1'b1;
          out_nxt.out_of_range = 1'b1;
          out_valid_nxt        = 1'b1;
        end
      end
      brds_pkg::ST_COUNT_EV: begin
        if (cmp.touched) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (at_last_idx) begin
          idx_nxt = '0;
          lo_nxt  = '0;
          k_nxt   = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
          lo_nxt  = rd_data_r;
        end
      end
      brds_pkg::ST_EMIT_EV: begin
        if (cmp.touched) begin
          out_nxt.piece_start  = cmp.piece_start;
          out_nxt.piece_end    = cmp.piece_end;
          out_nxt.device_index = brds_pkg::DEV_W'(idx_r);
          out_nxt.piece_count  = brds_pkg::CNT_W'(cnt_r);
          out_nxt.last         = ((k_r + 1'b1) == cnt_r);
          out_nxt.out_of_range = 1'b0;
          out_valid_nxt        = 1'b1;
          k_nxt                = k_r + 1'b1;
        end else if (!at_last_idx) begin
          idx_nxt = idx_r + 1'b1;
          lo_nxt  = rd_data_r;
        end
      end
      brds_pkg::ST_OUT: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          // The read address has not moved, so the boundary is still there.
          if (!out_r.last && !at_last_idx) begin
            idx_nxt = idx_r + 1'b1;
            lo_nxt  = rd_data_r;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= brds_pkg::ST_IDLE;
      total_r      <= '0;
      last_bound_r <= '0;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
      cnt_r        <= '0;
      k_r          <= '0;
    end else begin
      state_r      <= state_nxt;
      total_r      <= total_nxt;
      last_bound_r <= last_bound_nxt;
      out_valid_r  <= out_valid_nxt;
      idx_r        <= idx_nxt;
      cnt_r        <= cnt_nxt;
      k_r          <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rs_r  <= rs_nxt;
    re_r  <= re_nxt;
    lo_r  <= lo_nxt;
    out_r <= out_nxt;
  end

  `BRDS_ASSERT_NOW(a_total_bound, 1'b1, total_r <= AW'(MAX_DEVICES), "device count past maximum")
  `BRDS_ASSERT_NOW(a_flag_single, out_valid_r && out_r.out_of_range, out_r.last && out_r.piece_count == brds_pkg::CNT_W'(1), "flagged result is not a single piece")
  `BRDS_ASSERT_NOW(a_piece_order, out_valid_r && !out_r.out_of_range && state_r != brds_pkg::ST_IDLE && total_r > AW'(1), out_r.piece_start <= out_r.piece_end, "piece start beyond piece end")
  `BRDS_ASSERT_NEXT(a_more_pieces, out_acc && !out_r.last, state_r == brds_pkg::ST_EMIT_RD, "sweep did not resume after a piece")
  `BRDS_ASSERT_NOW(a_piece_budget, state_r == brds_pkg::ST_EMIT_EV, k_r < cnt_r, "more pieces than counted")

endmodule

@@ hdl/brds_cmp_unit.sv @@
// ----------------------------------------------------------------------------
// brds_cmp_unit
// Shared compare unit: checks one device window against the request range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brds_cmp_unit (
  input  logic [brds_pkg::DATA_W-1:0] lo,
  input  logic [brds_pkg::DATA_W-1:0] hi,
  input  logic [brds_pkg::DATA_W-1:0] rs,
  input  logic [brds_pkg::DATA_W-1:0] re,
  output brds_pkg::cmp_res_t          res
);

  logic nonempty;
  logic hi_gt_re;

  assign nonempty = hi > lo;
  assign hi_gt_re = hi > re;

  always_comb begin
    res.nonempty    = nonempty;
    // A nonempty device is touched when it starts at or before the end and
    // finishes after the start of the range.
    res.touched     = nonempty && (lo <= re) && (hi > rs);
    res.rs_gt_re    = rs > re;
    res.hi_gt_re    = hi_gt_re;
    res.piece_start = (lo > rs) ? lo : rs;
    res.piece_end   = hi_gt_re ? re : (hi - 1'b1);
  end

endmodule
